// ----- rtl/mvbm_pkg.sv -----
// ============================================================================
// mvbm_pkg
// Shared types and constants for the mesh volume / body measure block.
// ============================================================================
package mvbm_pkg;

    localparam int COORD_W = 24;
    localparam int ACC_W   = 62;
    localparam int VOL_W   = 48;
    localparam int MEAS_W  = 40;
    localparam int DENS_W  = 16;

    localparam logic [DENS_W-1:0] DENSITY_RESET = 16'd1026;
    // 256e9 = 5^9 * 2^17
    localparam logic [20:0] FIVE_POW9 = 21'd1953125;
    localparam int          ROOT_SHIFT = 17;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    // 6 * 2^40: magnitudes at or above this clip the volume
    localparam logic [ACC_W-1:0] VOL_LIMIT = 62'd6 << 40;

    typedef struct packed {
        logic                       last;
        logic signed [COORD_W-1:0]  cz;
        logic signed [COORD_W-1:0]  cy;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  bz;
        logic signed [COORD_W-1:0]  by_coord;
        logic signed [COORD_W-1:0]  bx;
        logic signed [COORD_W-1:0]  az;
        logic signed [COORD_W-1:0]  ay;
        logic signed [COORD_W-1:0]  ax;
    } tri_t;

    typedef struct packed {
        logic              saturated;
        logic [MEAS_W-1:0] body_measure;
        logic [VOL_W-1:0]  volume;
    } res_t;

endpackage

// ----- rtl/mvbm_front.sv -----
// ============================================================================
// mvbm_front
// Input stage: two-entry triangle queue between the stream port and the
// arithmetic sequencer.
// ============================================================================
module mvbm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mvbm_pkg::tri_t    in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output mvbm_pkg::tri_t    out_item
);

    mvbm_pkg::tri_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/mvbm_back.sv -----
// ============================================================================
// mvbm_back
// Sequencer: triple product on a shared 25x25 multiplier, saturating
// accumulate, divide by six, density scaling and bit-serial cube root.
// ============================================================================
module mvbm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       density,
    input  logic              in_valid,
    output logic              in_ready,
    input  mvbm_pkg::tri_t    in_item,
    output logic              res_valid,
    input  logic              res_ready,
    output mvbm_pkg::res_t    res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_XPROD = 3'd1;
    localparam logic [2:0] ST_ACCUM = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_MULK  = 3'd4;
    localparam logic [2:0] ST_ROOT  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam logic [6:0] XPROD_LAST = 7'd12;
    localparam logic [6:0] DIV_LAST   = 7'd6;
    localparam logic [6:0] MULK_LAST  = 7'd6;
    localparam logic [6:0] ROOT_LAST  = 7'd35;

    logic [2:0]          state_reg, state_next;
    logic [6:0]          step_reg, step_next;
    mvbm_pkg::tri_t      item_reg, item_next;
    logic signed [49:0]  prod_reg;
    logic signed [48:0]  cr_reg [3];
    logic signed [48:0]  cr_next [3];
    logic signed [75:0]  t_reg, t_next;
    logic signed [61:0]  acc_reg, acc_next;
    logic                sat_reg, sat_next;
    logic [69:0]         div_reg, div_next;
    logic [69:0]         quo_reg, quo_next;
    logic [47:0]         vol_reg, vol_next;
    logic [36:0]         k_reg, k_next;
    logic [84:0]         n_reg, n_next;
    logic [107:0]        rad_reg, rad_next;
    logic [35:0]         r_reg, r_next;
    logic [71:0]         sq_reg, sq_next;
    logic [79:0]         crem_reg, crem_next;

    logic signed [24:0]  mul_a, mul_b;
    logic [6:0]          kstep;
    logic [1:0]          cidx;
    logic signed [47:0]  tq;
    logic signed [62:0]  sum;
    logic signed [61:0]  acc_sat;
    logic [61:0]         mag;
    logic [5:0]          rfix;
    logic [3:0]          fix;
    logic [79:0]         rem_sh, tv;

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res.volume       = vol_reg;
    assign res.body_measure = {4'd0, r_reg};
    assign res.saturated    = sat_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_XPROD:
            begin
                priority case (step_reg)
                    7'd0:
                    begin
                        mul_a = 25'(item_reg.by_coord);
                        mul_b = 25'(item_reg.cz);
                    end
                    7'd1:
                    begin
                        mul_a = 25'(item_reg.bz);
                        mul_b = 25'(item_reg.cy);
                    end
                    7'd2:
                    begin
                        mul_a = 25'(item_reg.bz);
                        mul_b = 25'(item_reg.cx);
                    end
                    7'd3:
                    begin
                        mul_a = 25'(item_reg.bx);
                        mul_b = 25'(item_reg.cz);
                    end
                    7'd4:
                    begin
                        mul_a = 25'(item_reg.bx);
                        mul_b = 25'(item_reg.cy);
                    end
                    7'd5:
                    begin
                        mul_a = 25'(item_reg.by_coord);
                        mul_b = 25'(item_reg.cx);
                    end
                    7'd6:
                    begin
                        mul_a = 25'(item_reg.ax);
                        mul_b = {1'b0, cr_reg[0][23:0]};
                    end
                    7'd7:
                    begin
                        mul_a = 25'(item_reg.ax);
                        mul_b = cr_reg[0][48:24];
                    end
                    7'd8:
                    begin
                        mul_a = 25'(item_reg.ay);
                        mul_b = {1'b0, cr_reg[1][23:0]};
                    end
                    7'd9:
                    begin
                        mul_a = 25'(item_reg.ay);
                        mul_b = cr_reg[1][48:24];
                    end
                    7'd10:
                    begin
                        mul_a = 25'(item_reg.az);
                        mul_b = {1'b0, cr_reg[2][23:0]};
                    end
                    7'd11:
                    begin
                        mul_a = 25'(item_reg.az);
                        mul_b = cr_reg[2][48:24];
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            ST_MULK:
            begin
                priority case (step_reg)
                    7'd0:
                    begin
                        mul_a = {9'd0, density};
                        mul_b = {4'd0, mvbm_pkg::FIVE_POW9};
                    end
                    7'd2:
                    begin
                        mul_a = {1'b0, k_reg[23:0]};
                        mul_b = {1'b0, vol_reg[23:0]};
                    end
                    7'd3:
                    begin
                        mul_a = {1'b0, k_reg[23:0]};
                        mul_b = {1'b0, vol_reg[47:24]};
                    end
                    7'd4:
                    begin
                        mul_a = {12'd0, k_reg[36:24]};
                        mul_b = {1'b0, vol_reg[23:0]};
                    end
                    7'd5:
                    begin
                        mul_a = {12'd0, k_reg[36:24]};
                        mul_b = {1'b0, vol_reg[47:24]};
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        item_next  = item_reg;
        cr_next    = cr_reg;
        t_next     = t_reg;
        acc_next   = acc_reg;
        sat_next   = sat_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        vol_next   = vol_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        rad_next   = rad_reg;
        r_next     = r_reg;
        sq_next    = sq_reg;
        crem_next  = crem_reg;

        kstep  = step_reg - 7'd1;
        cidx   = kstep[2:1];
        tq     = 48'(t_reg >>> 28);
        sum    = 63'(acc_reg) + 63'(tq);
        if (sum > 63'(mvbm_pkg::ACC_MAX))
        begin
            acc_sat = mvbm_pkg::ACC_MAX;
        end
        else if (sum < 63'(mvbm_pkg::ACC_MIN))
        begin
            acc_sat = mvbm_pkg::ACC_MIN;
        end
        else
        begin
            acc_sat = sum[61:0];
        end
        mag    = acc_sat[61] ? 62'(-acc_sat) : acc_sat;

        // remainder left by the 1/3 series is below 45
        rfix = div_reg[5:0];
        fix  = '0;
        if (rfix >= 6'd24)
        begin
            rfix = rfix - 6'd24;
            fix  = fix + 4'd8;
        end
        if (rfix >= 6'd12)
        begin
            rfix = rfix - 6'd12;
            fix  = fix + 4'd4;
        end
        if (rfix >= 6'd6)
        begin
            rfix = rfix - 6'd6;
            fix  = fix + 4'd2;
        end
        if (rfix >= 6'd3)
        begin
            rfix = rfix - 6'd3;
            fix  = fix + 4'd1;
        end

        rem_sh = {crem_reg[76:0], rad_reg[107:105]};
        tv     = {5'd0, sq_reg, 3'd0} + {6'd0, sq_reg, 2'd0}
                 + {42'd0, r_reg, 2'd0} + {43'd0, r_reg, 1'b0} + 80'd1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_item;
                    step_next  = '0;
                    t_next     = '0;
                    state_next = ST_XPROD;
                end
            end
            ST_XPROD:
            begin
                if (step_reg != 7'd0)
                begin
                    if (kstep < 7'd6)
                    begin
                        if (!kstep[0])
                        begin
                            cr_next[cidx] = prod_reg[48:0];
                        end
                        else
                        begin
                            cr_next[cidx] = cr_reg[cidx] - prod_reg[48:0];
                        end
                    end
                    else if (!kstep[0])
                    begin
                        t_next = t_reg + 76'(prod_reg);
                    end
                    else
                    begin
                        t_next = t_reg + (76'(prod_reg) <<< 24);
                    end
                end
                step_next = step_reg + 7'd1;
                if (step_reg == XPROD_LAST)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                if (item_reg.last)
                begin
                    acc_next   = '0;
                    sat_next   = (mag >= mvbm_pkg::VOL_LIMIT);
                    div_next   = {1'b0, mag, 7'd0};
                    step_next  = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    acc_next   = acc_sat;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                // mag * 128 / 3: shift-add series for 1/3, then remainder fix
                priority case (step_reg)
                    7'd0: quo_next = {2'd0, div_reg[69:2]} + {4'd0, div_reg[69:4]};
                    7'd1: quo_next = quo_reg + {4'd0, quo_reg[69:4]};
                    7'd2: quo_next = quo_reg + {8'd0, quo_reg[69:8]};
                    7'd3: quo_next = quo_reg + {16'd0, quo_reg[69:16]};
                    7'd4: quo_next = quo_reg + {32'd0, quo_reg[69:32]};
                    7'd5: div_next = div_reg - quo_reg - {quo_reg[68:0], 1'b0};
                    default: quo_next = quo_reg + {66'd0, fix};
                endcase
                step_next = step_reg + 7'd1;
                if (step_reg == DIV_LAST)
                begin
                    vol_next   = sat_reg ? '1 : quo_next[47:0];
                    step_next  = '0;
                    n_next     = '0;
                    state_next = ST_MULK;
                end
            end
            ST_MULK:
            begin
                priority case (step_reg)
                    7'd1: k_next = prod_reg[36:0];
                    7'd3: n_next = 85'(prod_reg[47:0]);
                    7'd4: n_next = n_reg + (85'(prod_reg[47:0]) << 24);
                    7'd5: n_next = n_reg + (85'(prod_reg[47:0]) << 24);
                    7'd6: n_next = n_reg + (85'(prod_reg[47:0]) << 48);
                    default: n_next = n_reg;
                endcase
                step_next = step_reg + 7'd1;
                if (step_reg == MULK_LAST)
                begin
                    rad_next   = 108'(n_next) << mvbm_pkg::ROOT_SHIFT;
                    r_next     = '0;
                    sq_next    = '0;
                    crem_next  = '0;
                    step_next  = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (rem_sh >= tv)
                begin
                    crem_next = rem_sh - tv;
                    r_next    = {r_reg[34:0], 1'b1};
                    sq_next   = {sq_reg[69:0], 2'd0} + {34'd0, r_reg, 2'd0} + 72'd1;
                end
                else
                begin
                    crem_next = rem_sh;
                    r_next    = {r_reg[34:0], 1'b0};
                    sq_next   = {sq_reg[69:0], 2'd0};
                end
                rad_next  = {rad_reg[104:0], 3'd0};
                step_next = step_reg + 7'd1;
                if (step_reg == ROOT_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        item_reg <= item_next;
        cr_reg   <= cr_next;
        t_reg    <= t_next;
        div_reg  <= div_next;
        quo_reg  <= quo_next;
        vol_reg  <= vol_next;
        k_reg    <= k_next;
        n_reg    <= n_next;
        rad_reg  <= rad_next;
        r_reg    <= r_next;
        sq_reg   <= sq_next;
        crem_reg <= crem_next;
        sat_reg  <= sat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

// ----- rtl/mesh_volume_body_measure_unit.sv -----
// ============================================================================
// mesh_volume_body_measure_unit
// Signed-tetrahedron mesh volume with a cube-root body measure.
// ============================================================================
//  channel   direction  transaction
//  s_*       in         one triangle (9 coords), tlast = last triangle of mesh
//  m_*       out        volume and body measure, tuser = saturated
//  cfg_*     in         density write
//
//  In the sequencer a triangle is loaded, takes 12 products on one shared
//  25x25 multiplier and is accumulated. The last triangle of a mesh adds
//  the divide, scaling, cube-root and hand-off states. A two-entry queue
//  takes triangles while the sequencer works; an output register holds
//  the result while m_tready is low. Reset clears the sum and sets density
//  to 1026.
// ============================================================================
module mesh_volume_body_measure_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [215:0] s_tdata,   // ax, ay, az, bx, by_coord, bz, cx, cy, cz
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,   // volume, body_measure
    output logic [0:0]   m_tuser,   // saturated
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);

    mvbm_pkg::tri_t in_item, q_item;
    mvbm_pkg::res_t res, out_res_reg;
    logic           q_valid, q_ready;
    logic           res_valid, res_ready;
    logic           out_valid_reg, out_valid_next;
    logic [15:0]    density_reg;

    assign in_item = {s_tlast, s_tdata};
    assign cfg_ready = 1'b1;

    mvbm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    mvbm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .density   (density_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            density_reg   <= mvbm_pkg::DENSITY_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                density_reg <= cfg_data;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.body_measure, out_res_reg.volume};
    assign m_tuser  = out_res_reg.saturated;

    a_sat_volume: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[47:0] == 48'hFFFF_FFFF_FFFF))
        else $error("saturated result without clipped volume");

    a_zero_measure: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[47:0] == 48'd0) |-> (m_tdata[87:48] == 40'd0))
        else $error("nonzero measure for zero volume");

    a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result dropped while output register full");

endmodule

// ----- dv/tb.sv -----
// ============================================================================
// tb
// Testbench for mesh_volume_body_measure_unit. It streams triangles with
// random bursts and gaps, and stalls the result side on its own pattern. It
// predicts every volume, body measure and saturation flag, and checks each
// result transaction against the oldest prediction.
// ============================================================================
module tb;

    localparam logic signed [63:0] SUM_MAX = 64'sh1FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = -SUM_MAX - 64'sd1;
    localparam logic signed [23:0] CMAX    = 24'sh7FFFFF;
    localparam logic signed [23:0] CMIN    = -24'sh800000;
    localparam int                 SETTLE  = 200;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [215:0] s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [87:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [15:0]  cfg_data;

    logic signed [63:0] mesh_sum;
    logic [15:0]        density_q;
    mvbm_pkg::res_t     pending_results[$];
    int                 mismatches;
    int                 burst_left;
    int                 stall_pct;
    int                 stall_cycles;

    mesh_volume_body_measure_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // a.(b x c) with 60 fraction bits, floored to 32
    function automatic logic signed [63:0] triple_q32(mvbm_pkg::tri_t t);
        logic signed [79:0] a0, a1, a2, b0, b1, b2, c0, c1, c2, x0, x1, x2, dot;
        a0 = t.ax;  a1 = t.ay;       a2 = t.az;
        b0 = t.bx;  b1 = t.by_coord; b2 = t.bz;
        c0 = t.cx;  c1 = t.cy;       c2 = t.cz;
        x0 = b1 * c2 - b2 * c1;
        x1 = b2 * c0 - b0 * c2;
        x2 = b0 * c1 - b1 * c0;
        dot = a0 * x0 + a1 * x1 + a2 * x2;
        dot = dot >>> 28;
        return dot[63:0];
    endfunction

    function automatic logic [39:0] cube_root(logic [127:0] n);
        logic [127:0] root;
        logic [127:0] y;
        root = '0;
        for (int bit_i = 35; bit_i >= 0; bit_i--)
        begin
            y = root | (128'd1 << bit_i);
            if (y * y * y <= n)
                root = y;
        end
        return root[39:0];
    endfunction

    task automatic predict_triangle(mvbm_pkg::tri_t t);
        logic signed [63:0] acc;
        logic [63:0]        mag;
        logic [63:0]        q;
        logic [63:0]        r;
        logic [127:0]       scaled;
        mvbm_pkg::res_t     res;
        acc = mesh_sum + triple_q32(t);
        if (acc > SUM_MAX)
            acc = SUM_MAX;
        if (acc < SUM_MIN)
            acc = SUM_MIN;
        mesh_sum = acc;
        if (t.last)
        begin
            mag = acc < 0 ? -acc : acc;
            q = mag / 64'd6;
            r = mag % 64'd6;
            res.saturated = 1'b0;
            if (q >= (64'd1 << 40))
            begin
                res.volume = '1;
                res.saturated = 1'b1;
            end
            else
            begin
                res.volume = 48'((q << 8) + (r << 8) / 64'd6);
            end
            scaled = 128'(density_q) * 128'(res.volume) * 128'd256000000000;
            res.body_measure = cube_root(scaled);
            pending_results.push_back(res);
            mesh_sum = '0;
        end
    endtask

    task automatic send_tri(mvbm_pkg::tri_t t);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= t[215:0];
        s_tlast  <= t.last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_triangle(t);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_density(logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        density_q = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? CMAX : CMIN;
            1: return 24'($signed($urandom_range(0, 2047)) - 1024);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic mvbm_pkg::tri_t rand_tri(logic last);
        mvbm_pkg::tri_t t;
        t.ax = rand_coord(); t.ay = rand_coord();       t.az = rand_coord();
        t.bx = rand_coord(); t.by_coord = rand_coord(); t.bz = rand_coord();
        t.cx = rand_coord(); t.cy = rand_coord();       t.cz = rand_coord();
        t.last = last;
        return t;
    endfunction

    function automatic mvbm_pkg::tri_t make_tri(logic signed [23:0] v[9], logic last);
        mvbm_pkg::tri_t t;
        t.ax = v[0]; t.ay = v[1];       t.az = v[2];
        t.bx = v[3]; t.by_coord = v[4]; t.bz = v[5];
        t.cx = v[6]; t.cy = v[7];       t.cz = v[8];
        t.last = last;
        return t;
    endfunction

    task automatic test_extremes();
        logic signed [23:0] v[9];
        v = '{default: 24'sd0};
        send_tri(make_tri(v, 1'b1));
        v = '{default: CMAX};
        send_tri(make_tri(v, 1'b1));
        v = '{default: CMIN};
        send_tri(make_tri(v, 1'b0));
        v = '{CMAX, 24'sd0, 24'sd0, 24'sd0, CMAX, 24'sd0, 24'sd0, 24'sd0, CMAX};
        send_tri(make_tri(v, 1'b1));
        v = '{CMIN, 24'sd0, 24'sd0, 24'sd0, CMIN, 24'sd0, 24'sd0, 24'sd0, CMIN};
        send_tri(make_tri(v, 1'b1));
        v = '{24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'sd1};
        send_tri(make_tri(v, 1'b1));
        v = '{-24'sd1, -24'sd1, -24'sd1, 24'sd5, -24'sd3, 24'sd7, 24'sd0, 24'sd2, -24'sd9};
        send_tri(make_tri(v, 1'b1));
        wait_drained();
    endtask

    // determinant-4 sign pattern at full scale clips the volume
    task automatic test_volume_clip();
        logic signed [23:0] v[9];
        v = '{CMAX, CMAX, CMAX, CMAX, -CMAX, CMAX, CMAX, CMAX, -CMAX};
        send_tri(make_tri(v, 1'b1));
        v = '{CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX};
        send_tri(make_tri(v, 1'b1));
        v = '{CMAX, CMAX, CMAX, CMAX, -CMAX, CMAX, CMAX, CMAX, -CMAX};
        send_tri(make_tri(v, 1'b0));
        v = '{CMAX, 24'sd0, 24'sd0, 24'sd0, CMAX, 24'sd0, 24'sd0, 24'sd0, CMAX};
        send_tri(make_tri(v, 1'b1));
        wait_drained();
    endtask

    task automatic test_density_sweep();
        logic [15:0] settings[4];
        settings = '{16'd0, 16'd1, 16'hFFFF, 16'd1026};
        foreach (settings[i])
        begin
            write_density(settings[i]);
            send_tri(rand_tri(1'b0));
            send_tri(rand_tri(1'b1));
            send_tri(rand_tri(1'b1));
            wait_drained();
        end
    endtask

    task automatic test_random_meshes(int n_items);
        int sent;
        int mesh_len;
        sent = 0;
        while (sent < n_items)
        begin
            mesh_len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3)
                                                  : $urandom_range(4, 30);
            for (int i = 0; i < mesh_len; i++)
                send_tri(rand_tri(i == mesh_len - 1));
            sent += mesh_len;
            if ($urandom_range(0, 7) == 0)
            begin
                wait_drained();
                write_density(16'($urandom_range(0, 65535)));
            end
        end
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: %h %b", m_tdata, m_tuser);
                end
                else
                begin
                    mvbm_pkg::res_t exp_res;
                    exp_res = pending_results.pop_front();
                    if (m_tdata[47:0] !== exp_res.volume
                        || m_tdata[87:48] !== exp_res.body_measure
                        || m_tuser[0] !== exp_res.saturated)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: vol exp %h got %h, meas exp %h got %h,",
                                      " sat exp %b got %b"},
                                     exp_res.volume, m_tdata[47:0], exp_res.body_measure,
                                     m_tdata[87:48], exp_res.saturated, m_tuser[0]);
                    end
                end
            end
            stall_cycles++;
            if (stall_cycles % 400 == 0)
                stall_pct = $urandom_range(0, 2) * 40;
            m_tready <= $urandom_range(0, 99) >= stall_pct;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mesh_sum = '0;
        density_q = mvbm_pkg::DENSITY_RESET;
        mismatches = 0;
        burst_left = 0;
        stall_pct = 0;
        stall_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_volume_clip();
        test_density_sweep();
        test_random_meshes(1000);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("tb failed");
        $finish;
    end
endmodule
